@@ rtl/fb_pkg.sv @@
// ----------------------------------------------------------------------------
// fb_pkg
// Shared constants and types for the frame builder with XOR parity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fb_pkg;

  localparam logic [7:0] START_BYTE   = 8'h7E;
  localparam logic [2:0] SEQ_LOW_MASK = 3'h7;

  localparam int unsigned GRP_BYTES   = 4;   // most bytes one item can cause
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CNT_W       = $clog2(GRP_BYTES + 1);
  localparam int unsigned IDX_W       = $clog2(GRP_BYTES);

  // Bytes caused by one accepted item, oldest first.
  typedef struct packed {
    logic [GRP_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;   // 0 = item caused nothing
    logic                      closes;  // last byte is the parity byte
  } fb_group_t;

endpackage

`default_nettype wire

@@ rtl/fb_in_if.sv @@
// ----------------------------------------------------------------------------
// fb_in_if
// Input channel: header or data items, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fb_in_if;
  logic       valid;
  logic       ready;
  logic       is_header;
  logic [4:0] msg_type;
  logic [5:0] seq_num;
  logic [4:0] payload_len;
  logic [7:0] data_byte;

  modport source (output valid, is_header, msg_type, seq_num, payload_len, data_byte,
                  input ready);
  modport sink   (input valid, is_header, msg_type, seq_num, payload_len, data_byte,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/fb_out_if.sv @@
// ----------------------------------------------------------------------------
// fb_out_if
// Output channel: serialized frame bytes, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

`default_nettype wire

@@ rtl/fb_frame_ctl.sv @@
// ----------------------------------------------------------------------------
// fb_frame_ctl
// Frame state and byte group builder; one accepted item per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fb_frame_ctl
  import fb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       is_header,
  input  wire logic [4:0] msg_type,
  input  wire logic [5:0] seq_num,
  input  wire logic [4:0] payload_len,
  input  wire logic [7:0] data_byte,
  input  wire logic       grp_take,
  output fb_group_t       grp,
  output logic            grp_valid
);

  logic             frame_open, frame_open_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]       running_parity, running_parity_next;
  fb_group_t        grp_next;

  logic [7:0]       h1, h2, par_hdr, par_data;
  logic [LEN_W-1:0] rem_dec;

  always_comb begin
    h1       = {payload_len, seq_num[5:3] & SEQ_LOW_MASK};
    h2       = {seq_num[2:0] & SEQ_LOW_MASK, msg_type};
    par_hdr  = h1 ^ h2;
    par_data = running_parity ^ data_byte;
    rem_dec  = bytes_remaining - LEN_W'(1);

    frame_open_next      = frame_open;
    bytes_remaining_next = bytes_remaining;
    running_parity_next  = running_parity;
    grp_next             = '0;

    if (is_header) begin
      grp_next.bytes[0] = START_BYTE;
      grp_next.bytes[1] = h1;
      grp_next.bytes[2] = h2;
      if (payload_len == '0) begin
        grp_next.bytes[3]    = par_hdr;
        grp_next.count       = CNT_W'(4);
        grp_next.closes      = 1'b1;
        frame_open_next      = 1'b0;
        bytes_remaining_next = '0;
        running_parity_next  = '0;
      end else begin
        grp_next.count       = CNT_W'(3);
        frame_open_next      = 1'b1;
        bytes_remaining_next = payload_len;
        running_parity_next  = par_hdr;
      end
    end else if (frame_open) begin
      grp_next.bytes[0]    = data_byte;
      bytes_remaining_next = rem_dec;
      running_parity_next  = par_data;
      if (rem_dec == '0) begin
        grp_next.bytes[1]   = par_data;
        grp_next.count      = CNT_W'(2);
        grp_next.closes     = 1'b1;
        frame_open_next     = 1'b0;
        running_parity_next = '0;
      end else begin
        grp_next.count = CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= '0;
      running_parity  <= '0;
      grp_valid       <= 1'b0;
    end else begin
      if (accept) begin
        frame_open      <= frame_open_next;
        bytes_remaining <= bytes_remaining_next;
        running_parity  <= running_parity_next;
      end
      if (accept && grp_next.count != '0) begin
        grp_valid <= 1'b1;
      end else if (grp_take) begin
        grp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grp <= grp_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fb_serial.sv @@
// ----------------------------------------------------------------------------
// fb_serial
// Byte serializer: takes one group, hands it out one beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fb_serial
  import fb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire fb_group_t grp,
  input  wire logic      grp_valid,
  output logic           grp_take,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [7:0]     out_byte,
  output logic           frame_end
);

  logic [GRP_BYTES-1:0][7:0] bytes;
  logic [CNT_W-1:0]          left;
  logic [IDX_W-1:0]          idx;
  logic                      closes;
  logic                      beat, free;

  assign out_valid = (left != '0);
  assign beat      = out_valid && out_ready;
  // free when empty or when the last pending beat goes this cycle
  assign free      = (left == '0) || (left == CNT_W'(1) && out_ready);
  assign grp_take  = grp_valid && free;
  assign out_byte  = bytes[idx];
  assign frame_end = closes && (left == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      idx  <= '0;
    end else if (grp_take) begin
      left <= grp.count;
      idx  <= '0;
    end else if (beat) begin
      left <= left - CNT_W'(1);
      idx  <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take) begin
      bytes  <= grp.bytes;
      closes <= grp.closes;
    end
  end

endmodule

`default_nettype wire

@@ rtl/frame_builder_xor_parity.sv @@
// ----------------------------------------------------------------------------
// frame_builder_xor_parity
// Link frame builder: start byte, packed header, payload, XOR parity byte.
// ----------------------------------------------------------------------------
//
//  port   | dir  | beat carries
//  -------+------+-----------------------------------------------------------
//  item   | sink | is_header, msg_type, seq_num, payload_len, data_byte
//  frame  | src  | out_byte, frame_end (high on the parity byte only)
//
//  One item is taken per cycle while the group register is free; the serializer
//  sends one byte per cycle while frame.ready is high, so frame sets the pace: a
//  header makes 3 bytes (4 with empty payload), a data beat 1 (2 if it closes).
//  Group register plus serializer act as a skid: the next item is taken
//  while the last byte of the previous one still waits on frame.ready.
//  rst (synchronous) closes any frame and drops pending bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frame_builder_xor_parity
  import fb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  fb_in_if.sink     item,
  fb_out_if.source  frame
);

  fb_group_t grp;
  logic      grp_valid;
  logic      grp_take;
  logic      accept;

  // group register empties this cycle or already is empty
  assign item.ready = !grp_valid || grp_take;
  assign accept     = item.valid && item.ready;

  fb_frame_ctl u_ctl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .is_header   (item.is_header),
    .msg_type    (item.msg_type),
    .seq_num     (item.seq_num),
    .payload_len (item.payload_len),
    .data_byte   (item.data_byte),
    .grp_take    (grp_take),
    .grp         (grp),
    .grp_valid   (grp_valid)
  );

  fb_serial u_ser (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_take  (grp_take),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_byte  (frame.out_byte),
    .frame_end (frame.frame_end)
  );

endmodule

`default_nettype wire

@@ rtl/fb_checker.sv @@
// ----------------------------------------------------------------------------
// fb_checker
// Port-level checks for the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fb_checker
  import fb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       frame_end
);

  logic after_end;
  logic out_beat;

  assign out_beat = out_valid && out_ready;

  // set after reset and after each closing beat: next byte opens a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      after_end <= 1'b1;
    end else if (out_beat) begin
      after_end <= frame_end;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end))
    else $error("frame beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pending beats after reset");

  a_start_first: assert property (@(posedge clk) disable iff (rst)
    out_beat && after_end |-> out_byte == START_BYTE && !frame_end)
    else $error("frame does not open with the start byte");

  a_no_input_no_output: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && !$past(in_valid) |-> !out_valid)
    else $error("output beat with no item taken");

endmodule

bind frame_builder_xor_parity fb_checker u_fb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (frame.valid),
  .out_ready (frame.ready),
  .out_byte  (frame.out_byte),
  .frame_end (frame.frame_end)
);

`default_nettype wire
